/* rtl/core/dpta_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpta_pkg
// Shared types and constants of the demand paging table allocator: request
// and response beats, table entry layout, status codes, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dpta_pkg;

   localparam int SLOT_W      = 8;
   localparam int PAGE_W      = 8;
   localparam int FRAME_W     = 8;
   localparam int REFS_W      = 8;
   localparam int FAULT_W     = 16;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_SLOTS   = 256;
   localparam int MAX_PAGES   = 256;
   localparam int ENTRY_DEPTH = MAX_SLOTS * MAX_PAGES;
   localparam int ENTRY_ADDR_W = SLOT_W + PAGE_W;

   localparam logic [COUNT_W-1:0] FRAME_CAP       = COUNT_W'(256);
   localparam logic [COUNT_W-1:0] SLOT_CAP        = COUNT_W'(MAX_SLOTS);
   localparam logic [COUNT_W-1:0] TOTAL_FRAMES_RST = COUNT_W'(256);
   localparam logic [COUNT_W-1:0] TABLE_FRAMES_RST = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] PAGES_RST       = COUNT_W'(256);
   localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;
   localparam logic [PAGE_W-1:0]  LAST_PAGE       = PAGE_W'(MAX_PAGES - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_FRAMES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_FRAMES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGES        = 2'd2;

   typedef enum logic {
      CMD_CREATE    = 1'b0,
      CMD_REFERENCE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FAULT = 2'd1,
      STATUS_OOM   = 2'd2,
      STATUS_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_CLEAR = 2'd2
   } state_type;

   typedef struct packed {
      command_type         command;
      logic [SLOT_W-1:0]   slot;
      logic [PAGE_W-1:0]   page;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [FRAME_W-1:0]  frame;
      logic [REFS_W-1:0]   ref_count;
      logic [FAULT_W-1:0]  fault_count;
      logic [SLOT_W-1:0]   new_slot;
      logic [COUNT_W-1:0]  frames_used;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [REFS_W-1:0]   refs;
      logic [FRAME_W-1:0]  frame;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic clear_step;
      logic csr_write;
   } dp_cmd_type;

   typedef struct packed {
      logic create_ok;
      logic clear_last;
   } dp_stat_type;

endpackage
`default_nettype wire

/* rtl/core/dpta_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dpta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/dpta_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpta_ctrl
// Controller: accepts commands and register writes, sequences the evaluate
// cycle and the table clearing sweep of a create.
// ----------------------------------------------------------------------------
module dpta_ctrl
   import dpta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.create_ok ? ST_CLEAR : ST_IDLE;
         end
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy           = (state_ff != ST_IDLE);
      csr_ready      = (state_ff == ST_IDLE);
      cmd.capture    = (state_ff == ST_IDLE) && start;
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.csr_write  = (state_ff == ST_IDLE) && csr_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/dpta_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpta_dp
// Datapath: configuration registers, frame and slot allocators, page table
// and fault count memories, decision logic and the response register.
// ----------------------------------------------------------------------------
module dpta_dp
   import dpta_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire req_type                req_data,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_wdata,
   input  wire dp_cmd_type             cmd,
   output dp_stat_type                 stat,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data
);

   logic [COUNT_W-1:0] total_frames_ff;
   logic [COUNT_W-1:0] table_frames_ff;
   logic [COUNT_W-1:0] pages_ff;
   logic [COUNT_W-1:0] slots_created_ff;
   logic [COUNT_W-1:0] slots_created_in;
   logic [COUNT_W-1:0] next_free_ff;
   logic [COUNT_W-1:0] next_free_in;
   logic               oom_ff;
   logic               oom_in;
   command_type        op_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [SLOT_W-1:0]  clr_slot_ff;
   logic [PAGE_W-1:0]  clr_cnt_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   entry_type          entry_rd;
   entry_type          entry_wr;
   logic               entry_we;
   logic [ENTRY_ADDR_W-1:0] entry_waddr;
   logic [FAULT_W-1:0] faults_rd;
   logic [FAULT_W-1:0] faults_wr;
   logic               faults_we;
   logic [SLOT_W-1:0]  faults_waddr;

   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] need;
   logic [COUNT_W:0]   fit_sum;
   logic               fits;
   logic               bad_ref;
   logic               create_ok;
   logic [REFS_W-1:0]  refs_inc;
   logic [FAULT_W-1:0] faults_inc;

   dpta_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
      .clock    (clock),
      .we       (entry_we),
      .waddr    (entry_waddr),
      .wdata    (entry_wr),
      .re       (cmd.capture),
      .raddr    ({req_data.slot, req_data.page}),
      .rdata_ff (entry_rd)
   );

   dpta_ram #(.WIDTH(FAULT_W), .DEPTH(MAX_SLOTS)) u_fault_ram (
      .clock    (clock),
      .we       (faults_we),
      .waddr    (faults_waddr),
      .wdata    (faults_wr),
      .re       (cmd.capture),
      .raddr    (req_data.slot),
      .rdata_ff (faults_rd)
   );

   always_comb begin
      limit      = (total_frames_ff > FRAME_CAP) ? FRAME_CAP : total_frames_ff;
      need       = (table_frames_ff == '0) ? COUNT_W'(1) : table_frames_ff;
      fit_sum    = {1'b0, next_free_ff} + {1'b0, need};
      fits       = (fit_sum <= {1'b0, limit});
      bad_ref    = ({1'b0, slot_ff} >= slots_created_ff) || ({1'b0, page_ff} >= pages_ff);
      refs_inc   = entry_rd.refs + REFS_W'(1);
      faults_inc = (faults_rd == FAULT_MAX) ? faults_rd : faults_rd + FAULT_W'(1);

      rsp_data_in      = '0;
      next_free_in     = next_free_ff;
      slots_created_in = slots_created_ff;
      oom_in           = oom_ff;
      create_ok        = 1'b0;
      entry_wr         = '0;
      entry_we         = 1'b0;
      faults_wr        = '0;
      faults_we        = 1'b0;
      faults_waddr     = slot_ff;

      priority if (oom_ff) begin
         rsp_data_in.status = STATUS_OOM;
      end else if (op_ff == CMD_CREATE) begin
         priority if (slots_created_ff == SLOT_CAP) begin
            rsp_data_in.status = STATUS_BAD;
         end else if (!fits) begin
            rsp_data_in.status = STATUS_OOM;
            oom_in = 1'b1;
            if (next_free_ff < limit) next_free_in = limit;
         end else begin
            rsp_data_in.status   = STATUS_OK;
            rsp_data_in.frame    = next_free_ff[FRAME_W-1:0];
            rsp_data_in.new_slot = slots_created_ff[SLOT_W-1:0];
            next_free_in     = fit_sum[COUNT_W-1:0];
            slots_created_in = slots_created_ff + COUNT_W'(1);
            faults_waddr     = slots_created_ff[SLOT_W-1:0];
            faults_we        = 1'b1;
            create_ok        = 1'b1;
         end
      end else begin
         priority if (bad_ref) begin
            rsp_data_in.status = STATUS_BAD;
         end else if (entry_rd.valid) begin
            rsp_data_in.status      = STATUS_OK;
            rsp_data_in.frame       = entry_rd.frame;
            rsp_data_in.ref_count   = refs_inc;
            rsp_data_in.fault_count = faults_rd;
            entry_wr       = entry_rd;
            entry_wr.refs  = refs_inc;
            entry_we       = 1'b1;
         end else if (next_free_ff >= limit) begin
            rsp_data_in.status = STATUS_OOM;
            oom_in = 1'b1;
         end else begin
            rsp_data_in.status      = STATUS_FAULT;
            rsp_data_in.frame       = next_free_ff[FRAME_W-1:0];
            rsp_data_in.ref_count   = REFS_W'(1);
            rsp_data_in.fault_count = faults_inc;
            entry_wr.valid = 1'b1;
            entry_wr.refs  = REFS_W'(1);
            entry_wr.frame = next_free_ff[FRAME_W-1:0];
            entry_we       = 1'b1;
            faults_wr      = faults_inc;
            faults_we      = 1'b1;
            next_free_in   = next_free_ff + COUNT_W'(1);
         end
      end
      rsp_data_in.frames_used = next_free_in;

      entry_waddr = {slot_ff, page_ff};
      if (cmd.clear_step) begin
         entry_waddr = {clr_slot_ff, clr_cnt_ff};
         entry_wr    = '0;
         entry_we    = 1'b1;
      end else begin
         entry_we  = entry_we && cmd.exec;
      end
      faults_we = faults_we && cmd.exec;

      stat.create_ok  = create_ok;
      stat.clear_last = (clr_cnt_ff == LAST_PAGE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_frames_ff  <= TOTAL_FRAMES_RST;
         table_frames_ff  <= TABLE_FRAMES_RST;
         pages_ff         <= PAGES_RST;
         slots_created_ff <= '0;
         next_free_ff     <= '0;
         oom_ff           <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         if (cmd.csr_write) begin
            unique case (csr_index)
               CSR_TOTAL_FRAMES: total_frames_ff <= csr_wdata;
               CSR_TABLE_FRAMES: table_frames_ff <= csr_wdata;
               CSR_PAGES:        pages_ff        <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            slots_created_ff <= slots_created_in;
            next_free_ff     <= next_free_in;
            oom_ff           <= oom_in;
         end
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_data.command;
         slot_ff <= req_data.slot;
         page_ff <= req_data.page;
      end
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
         clr_slot_ff <= slots_created_ff[SLOT_W-1:0];
         clr_cnt_ff  <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff  <= clr_cnt_ff + PAGE_W'(1);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/core/demand_paging_table_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_table_allocator
// Single-level page tables per process slot over a bump frame allocator.
//
//   channel   ports                               handshake
//   request   start, busy, req_data               start & !busy
//   response  rsp_strobe, rsp_data                one-cycle strobe
//   config    csr_valid, csr_ready, csr_index,    csr_valid & csr_ready
//             csr_wdata
//
// A reference takes one table memory read, then an evaluate and write-back
// cycle; the response beat follows in the next cycle, while the next
// request may already be taken. A create that takes a slot goes on to a
// sweep that clears the valid marks of the new slot's 256 table entries,
// one a cycle through the single table write port; a create that is
// refused ends after its evaluate cycle. Reset needs no clearing pass.
// The response is never stalled; csr_ready is low while busy.
// ----------------------------------------------------------------------------
module demand_paging_table_allocator
   import dpta_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dpta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dpta_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/core/dpta_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpta_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dpta_checker
   import dpta_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response beat without a request in work");

   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response beats in consecutive cycles");

   a_fault_refs: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_FAULT |-> rsp_data.ref_count == REFS_W'(1))
      else $error("page fault beat with reference count other than one");

   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_OOM
         |-> rsp_data.frame == '0 && rsp_data.fault_count == '0)
      else $error("out of memory beat carries a mapping");

endmodule

bind demand_paging_table_allocator dpta_checker u_dpta_checker (.*);
`default_nettype wire

/* verif/demand_paging_table_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_table_allocator_tb
// Runs directed and random create/reference traffic through the allocator
// and checks every response beat against a behavioral copy of the page
// tables, frame allocator and fault counters. Register settings change
// between phases, and the sticky out-of-memory state is entered last.
// ----------------------------------------------------------------------------
module demand_paging_table_allocator_tb;
   import dpta_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_wdata;

   demand_paging_table_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // page tables, allocator and registers as the block should hold them
   bit                 mapped     [ENTRY_DEPTH];
   logic [FRAME_W-1:0] page_frame [ENTRY_DEPTH];
   logic [REFS_W-1:0]  page_refs  [ENTRY_DEPTH];
   logic [FAULT_W-1:0] slot_faults [MAX_SLOTS];
   int unsigned        slots_made;
   int unsigned        frames_used;
   bit                 oom;
   int unsigned        cfg_total;
   int unsigned        cfg_table;
   int unsigned        cfg_pages;

   int unsigned        mapped_keys [$];
   rsp_type            due_responses [$];
   int unsigned        mismatches;
   int unsigned        burst_left;

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   function automatic int unsigned frame_limit();
      return (cfg_total < FRAME_CAP) ? cfg_total : FRAME_CAP;
   endfunction

   function automatic int unsigned space_pages();
      return (cfg_pages < MAX_PAGES) ? cfg_pages : MAX_PAGES;
   endfunction

   function automatic int unsigned table_need();
      return (cfg_table == 0) ? 1 : cfg_table;
   endfunction

   function automatic rsp_type predict_access(input req_type item);
      rsp_type     r;
      int unsigned limit;
      int unsigned idx;
      r = '0;
      limit = frame_limit();
      idx = {item.slot, item.page};
      if (oom) begin
         r.status = STATUS_OOM;
      end else if (item.command == CMD_CREATE) begin
         if (slots_made >= MAX_SLOTS) begin
            r.status = STATUS_BAD;
         end else if (frames_used + table_need() > limit) begin
            if (frames_used < limit) frames_used = limit;
            oom = 1'b1;
            r.status = STATUS_OOM;
         end else begin
            r.status = STATUS_OK;
            r.frame = FRAME_W'(frames_used);
            r.new_slot = SLOT_W'(slots_made);
            slot_faults[slots_made] = '0;
            for (int p = 0; p < MAX_PAGES; p++) mapped[slots_made * MAX_PAGES + p] = 1'b0;
            slots_made++;
            frames_used += table_need();
         end
      end else if (item.slot >= slots_made || item.page >= space_pages()) begin
         r.status = STATUS_BAD;
      end else if (mapped[idx]) begin
         page_refs[idx] = page_refs[idx] + 1'b1;
         r.status = STATUS_OK;
         r.frame = page_frame[idx];
         r.ref_count = page_refs[idx];
         r.fault_count = slot_faults[item.slot];
      end else if (frames_used >= limit) begin
         oom = 1'b1;
         r.status = STATUS_OOM;
      end else begin
         page_frame[idx] = FRAME_W'(frames_used);
         page_refs[idx] = REFS_W'(1);
         mapped[idx] = 1'b1;
         mapped_keys.push_back(idx);
         frames_used++;
         if (slot_faults[item.slot] != FAULT_MAX)
            slot_faults[item.slot] = slot_faults[item.slot] + 1'b1;
         r.status = STATUS_FAULT;
         r.frame = page_frame[idx];
         r.ref_count = page_refs[idx];
         r.fault_count = slot_faults[item.slot];
      end
      r.frames_used = COUNT_W'(frames_used);
      return r;
   endfunction

   function automatic int unsigned frames_taken(input req_type item);
      if (oom) return 0;
      if (item.command == CMD_CREATE)
         return (slots_made < MAX_SLOTS) ? table_need() : 0;
      if (item.slot < slots_made && item.page < space_pages()
          && !mapped[{item.slot, item.page}])
         return 1;
      return 0;
   endfunction

   function automatic req_type make_req(input command_type cmd, input int unsigned slot,
                                        input int unsigned page);
      req_type item;
      item.command = cmd;
      item.slot = SLOT_W'(slot);
      item.page = PAGE_W'(page);
      return item;
   endfunction

   function automatic req_type make_bad_request();
      int unsigned np;
      np = space_pages();
      if (np < MAX_PAGES && ($urandom_range(0, 1) == 1 || slots_made >= MAX_SLOTS))
         return make_req(CMD_REFERENCE, $urandom_range(0, 255), $urandom_range(np, 255));
      return make_req(CMD_REFERENCE, $urandom_range(slots_made, 255), $urandom_range(0, 255));
   endfunction

   // favor recent mappings so that reference counts wrap
   function automatic bit pick_mapped(inout req_type item);
      int unsigned key;
      int unsigned n;
      n = mapped_keys.size();
      if (n == 0) return 1'b0;
      for (int tries = 0; tries < 8; tries++) begin
         if (n > 8 && $urandom_range(0, 1) == 1)
            key = mapped_keys[$urandom_range(n - 8, n - 1)];
         else
            key = mapped_keys[$urandom_range(0, n - 1)];
         if (key % MAX_PAGES < space_pages()) begin
            item = make_req(CMD_REFERENCE, key / MAX_PAGES, key % MAX_PAGES);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic req_type draw_request(input int unsigned budget);
      req_type     item;
      int unsigned roll;
      int unsigned np;
      np = space_pages();
      roll = $urandom_range(0, 99);
      item = make_req(CMD_REFERENCE, $urandom_range(0, 255), $urandom_range(0, 255));
      if (roll < 55) begin
         if (!pick_mapped(item)) item = make_bad_request();
      end else if (roll < 70 && slots_made > 0 && np > 0) begin
         item = make_req(CMD_REFERENCE, $urandom_range(0, slots_made - 1),
                         $urandom_range(0, np - 1));
      end else if (roll < 75) begin
         item.command = CMD_CREATE;
      end else if (roll < 88) begin
         item = make_bad_request();
      end else begin
         item.command = command_type'($urandom_range(0, 1));
      end
      if (frames_taken(item) > 0 && frames_used + frames_taken(item) > budget) begin
         if (!pick_mapped(item)) item = make_bad_request();
      end
      return item;
   endfunction

   function automatic int unsigned draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      due_responses.push_back(predict_access(item));
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      drain();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= COUNT_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_TOTAL_FRAMES: cfg_total = value;
         CSR_TABLE_FRAMES: cfg_table = value;
         CSR_PAGES:        cfg_pages = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_traffic(input int unsigned count, input int unsigned budget);
      repeat (count) send_item(draw_request(budget));
   endtask

   task automatic test_directed_basics();
      write_csr(CSR_TOTAL_FRAMES, 256);
      write_csr(CSR_TABLE_FRAMES, 1);
      write_csr(CSR_PAGES, 256);
      send_item(make_req(CMD_REFERENCE, 0, 0));
      send_item(make_req(CMD_CREATE, 0, 0));
      send_item(make_req(CMD_REFERENCE, 0, 255));
      send_item(make_req(CMD_REFERENCE, 0, 255));
      send_item(make_req(CMD_REFERENCE, 0, 0));
      send_item(make_req(CMD_REFERENCE, 1, 0));
      send_item(make_req(CMD_REFERENCE, 255, 255));
      send_item(make_req(CMD_CREATE, 255, 255));
      send_item(make_req(CMD_REFERENCE, 1, 128));
   endtask

   task automatic test_page_range();
      write_csr(CSR_PAGES, 4);
      send_item(make_req(CMD_REFERENCE, 0, 4));
      send_item(make_req(CMD_REFERENCE, 0, 3));
      send_item(make_req(CMD_REFERENCE, 0, 255));
      write_csr(CSR_PAGES, 0);
      send_item(make_req(CMD_REFERENCE, 0, 0));
      write_csr(CSR_PAGES, 511);
      send_item(make_req(CMD_REFERENCE, 0, 255));
   endtask

   task automatic test_table_sizes();
      write_csr(CSR_TABLE_FRAMES, 0);
      send_item(make_req(CMD_CREATE, 0, 0));
      write_csr(CSR_TABLE_FRAMES, 3);
      send_item(make_req(CMD_CREATE, 170, 85));
      send_item(make_req(CMD_REFERENCE, 3, 7));
   endtask

   task automatic test_ref_count_wrap();
      repeat (260) send_item(make_req(CMD_REFERENCE, 0, 255));
   endtask

   task automatic test_small_spaces();
      write_csr(CSR_TOTAL_FRAMES, 511);
      write_csr(CSR_TABLE_FRAMES, 2);
      write_csr(CSR_PAGES, 4);
      run_random_traffic(400, 60);
   endtask

   task automatic test_grown_spaces();
      write_csr(CSR_TOTAL_FRAMES, 256);
      write_csr(CSR_TABLE_FRAMES, 0);
      write_csr(CSR_PAGES, 511);
      run_random_traffic(600, 180);
   endtask

   task automatic test_single_page();
      write_csr(CSR_TOTAL_FRAMES, 300);
      write_csr(CSR_TABLE_FRAMES, 4);
      write_csr(CSR_PAGES, 1);
      run_random_traffic(300, 236);
   endtask

   task automatic test_no_frames();
      write_csr(CSR_TOTAL_FRAMES, 0);
      write_csr(CSR_PAGES, 256);
      run_random_traffic(150, 0);
      write_csr(CSR_TOTAL_FRAMES, 1);
      write_csr(CSR_TABLE_FRAMES, 511);
      write_csr(CSR_PAGES, 0);
      run_random_traffic(60, 0);
   endtask

   task automatic test_out_of_memory();
      write_csr(CSR_PAGES, 256);
      write_csr(CSR_TABLE_FRAMES, 256);
      write_csr(CSR_TOTAL_FRAMES, frames_used + 3);
      send_item(make_req(CMD_CREATE, 0, 0));
      send_item(make_req(CMD_REFERENCE, 0, 255));
      send_item(make_req(CMD_REFERENCE, 255, 0));
      write_csr(CSR_TABLE_FRAMES, 1);
      send_item(make_req(CMD_CREATE, 0, 0));
      repeat (20)
         send_item(make_req(command_type'($urandom_range(0, 1)), $urandom_range(0, 255),
                            $urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat %p", rsp_data);
         end else begin
            want = due_responses.pop_front();
            if (rsp_data.status !== want.status || rsp_data.frame !== want.frame
                || rsp_data.ref_count !== want.ref_count
                || rsp_data.fault_count !== want.fault_count
                || rsp_data.new_slot !== want.new_slot
                || rsp_data.frames_used !== want.frames_used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TOTAL_FRAMES;
      csr_wdata = '0;
      slots_made = 0;
      frames_used = 0;
      oom = 1'b0;
      cfg_total = TOTAL_FRAMES_RST;
      cfg_table = TABLE_FRAMES_RST;
      cfg_pages = PAGES_RST;
      mismatches = 0;
      burst_left = 0;
      foreach (slot_faults[i]) slot_faults[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_basics();
      test_page_range();
      test_table_sizes();
      test_ref_count_wrap();
      test_small_spaces();
      test_grown_spaces();
      test_single_page();
      test_no_frames();
      test_out_of_memory();

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && due_responses.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
